### rtl/core/page_write_count_threshold_sync_core_assert.svh
// Assertion macros shared by the page write counter RTL.
// Expect clk and rst_n in the including module; no other dependencies.
`ifndef PAGE_WRITE_COUNT_THRESHOLD_SYNC_CORE_ASSERT_SVH
`define PAGE_WRITE_COUNT_THRESHOLD_SYNC_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PWCT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwct assertion failed");

// Next-cycle implication, checked outside reset.
`define PWCT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwct assertion failed");

`endif

### rtl/core/pwct_pkg.sv
// Shared types and constants for the page write counter core.
// No dependencies; imported by pwct_ctrl, pwct_dp and the top level.
package pwct_pkg;

  localparam int PAGE_BYTES = 4096;
  localparam int MAX_PAGES  = 4096;

  localparam int ADDR_W     = 64;
  localparam int SIZE_W     = 7;
  localparam int LEN_W      = 25;
  localparam int THR_W      = 8;
  localparam int CNT_W      = 9;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PAGE_IDX_W = $clog2(MAX_PAGES);
  localparam int TRK_W      = PAGE_IDX_W + 1;
  localparam int OUT_PAGE_W = 12;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(194);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_ENABLE  = 2'd0,
    CFG_REGION_BASE    = 2'd1,
    CFG_REGION_LENGTH  = 2'd2,
    CFG_SYNC_THRESHOLD = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0] flush_address;
    logic [SIZE_W-1:0] flush_size;
  } in_item_t;

  typedef struct packed {
    logic [OUT_PAGE_W-1:0] page_index;
    logic [CNT_W-1:0]      write_count;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic capture;
    logic calc;
    logic read;
    logic update;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic hit;
  } stat_t;

endpackage

### rtl/core/pwct_ctrl.sv
// Sequencer for the page write counter core: clearing pass, then one
// request at a time through calc, read and, on a hit, update. Uses pwct_pkg.
module pwct_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  pwct_pkg::stat_t stat_i,
  output pwct_pkg::cmd_t  cmd_o
);
  import pwct_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_UPDATE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (stat_i.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (start) state_nxt = ST_CALC;
      ST_CALC:   state_nxt = ST_READ;
      ST_READ:   state_nxt = stat_i.hit ? ST_UPDATE : ST_IDLE;
      ST_UPDATE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
    busy_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.clear   = (state_r == ST_CLEAR);
    cmd_o.capture = (state_r == ST_IDLE) && start;
    cmd_o.calc    = (state_r == ST_CALC);
    cmd_o.read    = (state_r == ST_READ);
    cmd_o.update  = (state_r == ST_UPDATE);
  end

  assign busy = busy_r;

`include "page_write_count_threshold_sync_core_assert.svh"
  `PWCT_ASSERT_NXT(a_accept_to_calc, start && !busy_r, state_r == ST_CALC)
  `PWCT_ASSERT_NXT(a_read_exit, state_r == ST_READ,
                   state_r == ST_UPDATE || state_r == ST_IDLE)
  `PWCT_ASSERT_IMP(a_update_after_hit, state_r == ST_UPDATE,
                   $past(state_r == ST_READ) && $past(stat_i.hit))

endmodule

### rtl/core/pwct_dp.sv
// Datapath for the page write counter core: config registers, offset and
// range check, counter RAM and result register. Uses pwct_pkg.
module pwct_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pwct_pkg::cmd_t                  cmd_i,
  output pwct_pkg::stat_t                 stat_o,
  input  pwct_pkg::in_item_t              in_data,
  input  logic                            cfg_we,
  input  logic [pwct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwct_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                            out_valid,
  output pwct_pkg::out_item_t             out_data
);
  import pwct_pkg::*;

  // Configuration registers
  logic              enable_r;
  logic [ADDR_W-1:0] base_r;
  logic [LEN_W-1:0]  len_r;
  logic [THR_W-1:0]  thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      base_r   <= '0;
      len_r    <= '0;
      thr_r    <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REGION_ENABLE:  enable_r <= cfg_wdata[0];
        CFG_REGION_BASE:    base_r   <= cfg_wdata[ADDR_W-1:0];
        CFG_REGION_LENGTH:  len_r    <= cfg_wdata[LEN_W-1:0];
        CFG_SYNC_THRESHOLD: thr_r    <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture and offset stage
  logic [ADDR_W-1:0] addr_r;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] offset_r;
  logic              below_r;
  logic [ADDR_W:0]   diff;

  assign diff = {1'b0, addr_r} - {1'b0, base_r};

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      addr_r <= in_data.flush_address;
      size_r <= in_data.flush_size;
    end
    if (cmd_i.calc) begin
      offset_r <= diff[ADDR_W-1:0];
      below_r  <= diff[ADDR_W];
    end
  end

  // Only whole pages below the table size are tracked
  logic [LEN_W-1:0]      len_pages;
  logic [TRK_W-1:0]      tracked;
  logic                  upper_zero;
  logic                  hit;
  logic [PAGE_IDX_W-1:0] page;

  always_comb begin
    len_pages  = len_r >> PAGE_SHIFT;
    tracked    = (len_pages > LEN_W'(MAX_PAGES)) ? TRK_W'(MAX_PAGES)
                                                 : len_pages[TRK_W-1:0];
    upper_zero = ~|offset_r[ADDR_W-1:PAGE_SHIFT+TRK_W];
    hit        = enable_r && !below_r && upper_zero &&
                 (offset_r[PAGE_SHIFT +: TRK_W] < tracked);
    page       = offset_r[PAGE_SHIFT +: PAGE_IDX_W];
  end

  // Counter RAM, cleared by a sweep after reset
  logic [CNT_W-1:0]      mem [MAX_PAGES];
  logic [CNT_W-1:0]      rd_r;
  logic [PAGE_IDX_W-1:0] page_r;
  logic [PAGE_IDX_W-1:0] clr_idx_r;
  logic [CNT_W-1:0]      sum;
  logic                  sync;
  logic                  mem_we;
  logic [PAGE_IDX_W-1:0] mem_wa;
  logic [CNT_W-1:0]      mem_wd;

  always_comb begin
    sum  = rd_r + CNT_W'(size_r);
    sync = (sum >= CNT_W'(thr_r));
    priority if (cmd_i.clear) begin
      mem_we = 1'b1;
      mem_wa = clr_idx_r;
      mem_wd = '0;
    end else if (cmd_i.update) begin
      mem_we = 1'b1;
      mem_wa = page_r;
      mem_wd = sync ? '0 : sum;
    end else begin
      mem_we = 1'b0;
      mem_wa = page_r;
      mem_wd = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.read) begin
      rd_r   <= mem[page];
      page_r <= page;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd_i.clear) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  // Result register: one-cycle strobe
  logic      out_valid_r;
  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd_i.update && sync;
    end
    if (cmd_i.update) begin
      out_r.page_index  <= OUT_PAGE_W'(page_r);
      out_r.write_count <= sum;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_r;
  assign stat_o.clr_last = &clr_idx_r;
  assign stat_o.hit      = hit;

`include "page_write_count_threshold_sync_core_assert.svh"
  `PWCT_ASSERT_IMP(a_out_from_update, out_valid_r, $past(cmd_i.update))
  `PWCT_ASSERT_IMP(a_out_reaches_thr, out_valid_r,
                   out_r.write_count >= CNT_W'($past(thr_r)))
  `PWCT_ASSERT_NXT(a_out_strobe, out_valid_r, !out_valid_r)

endmodule

### rtl/core/page_write_count_threshold_sync_core.sv
// Per-page write counter with threshold sync: top level.
// Connects pwct_ctrl and pwct_dp; uses pwct_pkg.
//
// After reset the core sweeps its 4096-entry counter RAM to zero, holding
// busy high until the sweep ends; config writes are taken during the sweep.
// A flush request is taken when start is high and busy is low. Busy then
// stays high through the offset subtract, counter RAM read and counter
// update when the address lands on a tracked page, and through the
// subtract and read alone when it does not. The core takes a new request
// only once the last one is through, so the read-modify-write of one
// counter never overlaps another's. When the updated counter reaches
// sync_threshold, out_valid pulses for one cycle, the first cycle with
// busy low again, with out_data holding the page and the count, and the
// counter is cleared; the receiver cannot stall this strobe. Requests
// outside the enabled region produce no result. Write config only while
// busy is low and no result is pending.
module page_write_count_threshold_sync_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  pwct_pkg::in_item_t              in_data,
  output logic                            out_valid,
  output pwct_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [pwct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwct_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pwct_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pwct_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  pwct_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
